// ===== rtl/ldsvc_pkg.sv =====
// Package for the linear velocity command block.
// Widths, reset values, opcodes, register indices and the payload types.
// No dependencies.
package ldsvc_pkg;
  localparam int PosW   = 32;
  localparam int QuatW  = 16;
  localparam int GainW  = 16;
  localparam int LimW   = 31;
  localparam int VelW   = 41;
  localparam int SqW    = 84;
  localparam int RootW  = 42;
  localparam int ProdW  = 72;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 31;

  localparam logic signed [GainW-1:0] GainReset = -16'sd512;
  localparam logic [LimW-1:0] LimitReset = 31'd19661;

  localparam logic [1:0] OpMeas = 2'd0;
  localparam logic [1:0] OpTarget = 2'd1;
  localparam logic [1:0] OpTick = 2'd2;

  localparam logic [CfgIdxW-1:0] RegGain = 1'd0;
  localparam logic [CfgIdxW-1:0] RegLimit = 1'd1;

  typedef struct packed {
    logic [1:0] opcode;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [QuatW-1:0] quat_w;
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;
  } in_item_t;

  typedef struct packed {
    logic signed [PosW-1:0] vel_x;
    logic signed [PosW-1:0] vel_y;
    logic signed [PosW-1:0] vel_z;
    logic signed [QuatW-1:0] orient_w;
    logic signed [QuatW-1:0] orient_x;
    logic signed [QuatW-1:0] orient_y;
    logic signed [QuatW-1:0] orient_z;
    logic clamped;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic busy;
  } unit_ctl_t;
endpackage

// ===== rtl/ldsvc_if.sv =====
// Valid/ready channel carrying one payload beat.
// Depends on nothing; the payload type is a parameter.
interface ldsvc_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/linear_ds_velocity_command.sv =====
// Channel  Dir  Payload
// in       sink opcode, pos_x/y/z, quat_w/x/y/z
// out      src  vel_x/y/z, orient_w/x/y/z, clamped
// Position and target updates are registered as they are accepted. A tick
// after a position update runs the bit-serial multiplier for seven products
// (three gain products, three squares, the squared limit) to the result
// unclamped. Over the limit add the root and three products each followed
// by a divide. rst is synchronous and restores the register defaults. A
// result waits in the output register until taken; the next item is
// accepted meanwhile unless it is a tick after a position update.
module linear_ds_velocity_command (
  input logic clk,
  input logic rst,
  ldsvc_if.sink in_ch,
  ldsvc_if.source out_ch,
  input logic cfg_we,
  input logic [ldsvc_pkg::CfgIdxW-1:0] cfg_index,
  input logic [ldsvc_pkg::CfgDataW-1:0] cfg_data
);
  localparam int PW = ldsvc_pkg::PosW;
  localparam int VW = ldsvc_pkg::VelW;
  localparam int MW = 42;
  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_MULW = 4'd2,
    S_SQ = 4'd3, S_SQW = 4'd4, S_LIM = 4'd5, S_LIMW = 4'd6, S_ROOT = 4'd7,
    S_ROOTW = 4'd8, S_PM = 4'd9, S_PMW = 4'd10, S_DIV = 4'd11,
    S_DIVW = 4'd12, S_OUT = 4'd13;

  logic [3:0] state;
  logic [1:0] ax;
  logic pose_seen;
  logic signed [PW-1:0] meas [3];
  logic signed [PW-1:0] tgt [3];
  logic signed [ldsvc_pkg::QuatW-1:0] quat [4];
  logic signed [ldsvc_pkg::GainW-1:0] gain;
  logic [ldsvc_pkg::LimW-1:0] limit;
  logic signed [VW-1:0] vel [3];
  logic [ldsvc_pkg::SqW-1:0] sum;
  logic [ldsvc_pkg::RootW-1:0] nroot;
  logic [ldsvc_pkg::ProdW-1:0] pnum;
  logic clamp;
  ldsvc_pkg::out_item_t obuf;
  logic ovalid;

  logic [MW-1:0] ma, mb;
  logic [2*MW-1:0] mprod;
  ldsvc_pkg::unit_ctl_t mctl, rctl, dctl;
  logic [ldsvc_pkg::RootW-1:0] root;
  logic [ldsvc_pkg::ProdW-1:0] quot;

  logic signed [PW:0] diff;
  logic [PW:0] dmag;
  logic [VW-1:0] vmag;
  logic gneg, pneg;
  logic [VW+8:0] pfull;
  logic signed [VW+9:0] pfs;
  logic signed [VW+9:0] pfl;
  logic [ldsvc_pkg::RootW-1:0] nsafe;
  logic signed [VW-1:0] vres;

  assign diff = {meas[ax][PW-1], meas[ax]} - {tgt[ax][PW-1], tgt[ax]};
  assign dmag = diff[PW] ? (PW+1)'(-diff) : diff;
  assign gneg = gain[ldsvc_pkg::GainW-1];
  assign vmag = vel[ax][VW-1] ? VW'(-vel[ax]) : vel[ax];
  assign pneg = gneg ^ diff[PW];
  assign pfull = mprod[VW+8:0];
  assign pfs = pneg ? -$signed({1'b0, pfull}) : $signed({1'b0, pfull});
  assign pfl = pfs >>> 8;
  assign nsafe = (nroot == '0) ? ldsvc_pkg::RootW'(1) : nroot;
  assign vres = VW'(quot);

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_MUL: begin
        ma = MW'(dmag);
        mb = gneg ? MW'(-{{(MW-ldsvc_pkg::GainW){1'b1}}, gain})
                  : MW'({1'b0, gain});
      end
      S_SQ: begin
        ma = MW'(vmag);
        mb = MW'(vmag);
      end
      S_LIM: begin
        ma = MW'(limit);
        mb = MW'(limit);
      end
      S_PM: begin
        ma = MW'(vmag);
        mb = MW'(limit);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mctl.start = (state == S_MUL) || (state == S_SQ) || (state == S_LIM) ||
    (state == S_PM);
  assign rctl.start = (state == S_ROOT);
  assign dctl.start = (state == S_DIV);

  ldsvc_mul #(.AW(MW), .BW(MW)) u_mul (
    .clk(clk), .rst(rst), .start(mctl.start), .a(ma), .b(mb),
    .busy(mctl.busy), .prod(mprod)
  );
  ldsvc_root u_root (
    .clk(clk), .rst(rst), .start(rctl.start), .radicand(sum),
    .busy(rctl.busy), .root(root)
  );
  ldsvc_div u_div (
    .clk(clk), .rst(rst), .start(dctl.start), .dividend(pnum), .divisor(nsafe),
    .busy(dctl.busy), .quot(quot)
  );

  function automatic logic [PW-1:0] sat(input logic signed [VW-1:0] v);
    logic [PW-1:0] r;
    if (v > VW'($signed(32'h7fffffff))) r = 32'h7fffffff;
    else if (v < -(VW'(33'sh80000000))) r = 32'h80000000;
    else r = v[PW-1:0];
    return r;
  endfunction

  assign in_ch.ready = (state == S_IDLE) &&
    !(in_ch.data.opcode == ldsvc_pkg::OpTick && pose_seen && ovalid);
  assign out_ch.valid = ovalid;
  assign out_ch.data = obuf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pose_seen <= 1'b0;
      ovalid <= 1'b0;
      gain <= ldsvc_pkg::GainReset;
      limit <= ldsvc_pkg::LimitReset;
      ax <= '0;
      for (int i = 0; i < 3; i++) begin
        meas[i] <= '0;
        tgt[i] <= '0;
      end
      for (int i = 0; i < 4; i++) quat[i] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ldsvc_pkg::RegGain) gain <= cfg_data[15:0];
        else limit <= cfg_data;
      end
      if (out_ch.valid && out_ch.ready) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            unique case (in_ch.data.opcode)
              ldsvc_pkg::OpMeas: begin
                meas[0] <= in_ch.data.pos_x;
                meas[1] <= in_ch.data.pos_y;
                meas[2] <= in_ch.data.pos_z;
                pose_seen <= 1'b1;
              end
              ldsvc_pkg::OpTarget: begin
                tgt[0] <= in_ch.data.pos_x;
                tgt[1] <= in_ch.data.pos_y;
                tgt[2] <= in_ch.data.pos_z;
                quat[0] <= in_ch.data.quat_w;
                quat[1] <= in_ch.data.quat_x;
                quat[2] <= in_ch.data.quat_y;
                quat[3] <= in_ch.data.quat_z;
              end
              ldsvc_pkg::OpTick: begin
                if (pose_seen) begin
                  ax <= '0;
                  sum <= '0;
                  state <= S_MUL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MUL: state <= S_MULW;
        S_MULW: begin
          if (!mctl.busy) begin
            vel[ax] <= pfl[VW-1:0];
            if (ax == 2'd2) begin
              ax <= '0;
              state <= S_SQ;
            end else begin
              ax <= ax + 1'b1;
              state <= S_MUL;
            end
          end
        end
        S_SQ: state <= S_SQW;
        S_SQW: begin
          if (!mctl.busy) begin
            sum <= sum + mprod;
            if (ax == 2'd2) begin
              ax <= '0;
              state <= S_LIM;
            end else begin
              ax <= ax + 1'b1;
              state <= S_SQ;
            end
          end
        end
        S_LIM: state <= S_LIMW;
        S_LIMW: begin
          if (!mctl.busy) begin
            clamp <= sum > mprod;
            state <= (sum > mprod) ? S_ROOT : S_OUT;
          end
        end
        S_ROOT: state <= S_ROOTW;
        S_ROOTW: begin
          if (!rctl.busy) begin
            nroot <= root;
            state <= S_PM;
          end
        end
        S_PM: state <= S_PMW;
        S_PMW: begin
          if (!mctl.busy) begin
            pnum <= mprod[ldsvc_pkg::ProdW-1:0];
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_DIVW;
        S_DIVW: begin
          if (!dctl.busy) begin
            vel[ax] <= vel[ax][VW-1] ? -vres : vres;
            if (ax == 2'd2) begin
              ax <= '0;
              state <= S_OUT;
            end else begin
              ax <= ax + 1'b1;
              state <= S_PM;
            end
          end
        end
        S_OUT: begin
          if (!ovalid) begin
            obuf.vel_x <= sat(vel[0]);
            obuf.vel_y <= sat(vel[1]);
            obuf.vel_z <= sat(vel[2]);
            obuf.orient_w <= quat[0];
            obuf.orient_x <= quat[1];
            obuf.orient_y <= quat[2];
            obuf.orient_z <= quat[3];
            obuf.clamped <= clamp;
            ovalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/ldsvc_mul.sv =====
// Shift-and-add multiplier: one bit of the multiplier per cycle.
// Unsigned operands; depends on nothing.
module ldsvc_mul #(
  parameter int AW = 42,
  parameter int BW = 42
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic busy,
  output logic [AW+BW-1:0] prod
);
  localparam int CntW = $clog2(BW + 1);
  logic [AW+BW-1:0] acc;
  logic [AW+BW-1:0] mcand;
  logic [BW-1:0] mplier;
  logic [CntW-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CntW'(BW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
    if (start) begin
      acc <= '0;
      mcand <= {{BW{1'b0}}, a};
      mplier <= b;
    end else if (cnt != '0) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign busy = (cnt != '0);
  assign prod = acc;
endmodule

// ===== rtl/ldsvc_root.sv =====
// Restoring square root, one result bit per cycle.
// Depends on ldsvc_pkg for widths.
module ldsvc_root (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [ldsvc_pkg::SqW-1:0] radicand,
  output logic busy,
  output logic [ldsvc_pkg::RootW-1:0] root
);
  localparam int RW = ldsvc_pkg::RootW;
  localparam int CntW = $clog2(RW + 1);
  logic [2*RW-1:0] rad;
  logic [RW+1:0] rem;
  logic [RW-1:0] q;
  logic [CntW-1:0] cnt;
  logic [RW+1:0] rem_sh;
  logic [RW+1:0] trial;

  assign rem_sh = {rem[RW-1:0], rad[2*RW-1 -: 2]};
  assign trial = {q, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CntW'(RW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
    if (start) begin
      rad <= radicand;
      rem <= '0;
      q <= '0;
    end else if (cnt != '0) begin
      rad <= rad << 2;
      if (rem_sh >= trial) begin
        rem <= rem_sh - trial;
        q <= {q[RW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q <= {q[RW-2:0], 1'b0};
      end
    end
  end

  assign busy = (cnt != '0);
  assign root = q;
endmodule

// ===== rtl/ldsvc_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on ldsvc_pkg for widths.
module ldsvc_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [ldsvc_pkg::ProdW-1:0] dividend,
  input  logic [ldsvc_pkg::RootW-1:0] divisor,
  output logic busy,
  output logic [ldsvc_pkg::ProdW-1:0] quot
);
  localparam int PW = ldsvc_pkg::ProdW;
  localparam int DW = ldsvc_pkg::RootW;
  localparam int CntW = $clog2(PW + 1);
  logic [PW-1:0] q;
  logic [DW:0] rem;
  logic [DW-1:0] den;
  logic [CntW-1:0] cnt;
  logic [DW:0] rem_sh;

  assign rem_sh = {rem[DW-1:0], q[PW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CntW'(PW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
    if (start) begin
      q <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (cnt != '0) begin
      if (rem_sh >= {1'b0, den}) begin
        rem <= rem_sh - {1'b0, den};
        q <= {q[PW-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q <= {q[PW-2:0], 1'b0};
      end
    end
  end

  assign busy = (cnt != '0);
  assign quot = q;
endmodule
